// ----- sv/utilization_percent_bar_meter_core_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef UTILIZATION_PERCENT_BAR_METER_CORE_DEFINES_SVH
`define UTILIZATION_PERCENT_BAR_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UPBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UPBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/upbm_pkg.sv -----
package upbm_pkg;

   localparam int unsigned CntW    = 64;
   localparam int unsigned NumCtr  = 10;
   localparam int unsigned ProdW   = 71;   // 100 * (2^64 - 1) fits in 71 bits
   localparam int unsigned QuotW   = 7;
   localparam int unsigned PctW    = 7;
   localparam int unsigned BarW    = 10;
   localparam int unsigned StatW   = 2;
   localparam int unsigned BarStep = 10;

   localparam logic [StatW-1:0] ST_OK    = 2'd0;
   localparam logic [StatW-1:0] ST_FIRST = 2'd1;
   localparam logic [StatW-1:0] ST_ZERO  = 2'd2;
   localparam logic [StatW-1:0] ST_IDLE  = 2'd3;

   typedef struct packed {
      logic [CntW-1:0] user_ticks;
      logic [CntW-1:0] nice_ticks;
      logic [CntW-1:0] system_ticks;
      logic [CntW-1:0] idle_ticks;
      logic [CntW-1:0] iowait_ticks;
      logic [CntW-1:0] irq_ticks;
      logic [CntW-1:0] softirq_ticks;
      logic [CntW-1:0] steal_ticks;
      logic [CntW-1:0] guest_ticks;
      logic [CntW-1:0] guest_nice_ticks;
   } req_payload_type;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic [PctW-1:0]  busy_percent;
      logic [BarW-1:0]  led_bar;
   } rsp_payload_type;

   // Thermometer pattern with floor(pct / 10) LEDs lit from bit 0 upward, at most 10.
   function automatic logic [BarW-1:0] bar_of(input logic [PctW-1:0] pct);
      logic [BarW-1:0] bar;
      bar = '0;
      for (int i = 0; i < BarW; i++) begin
         bar[i] = (pct >= PctW'(BarStep * (i + 1)));
      end
      return bar;
   endfunction

endpackage

// ----- sv/upbm_chan_if.sv -----
interface upbm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/utilization_percent_bar_meter_core.sv -----
// Sequence after the accepting edge: a bit-serial pass over the 71-bit product
//   100*(dT-dI), 7 restoring-division steps, then a rounding/commit step that waits
//   while an earlier result is still offered and not taken. One item at a time: no new
//   item is taken until the commit, but the next item is taken while a result waits.
// Reset (synchronous, active high): idle, no result pending, not primed, all LEDs off.
module utilization_percent_bar_meter_core (
   input logic         clock,
   input logic         reset,
   upbm_chan_if.sink   req_chan,
   upbm_chan_if.source rsp_chan
);

   localparam int unsigned CntW  = upbm_pkg::CntW;
   localparam int unsigned ProdW = upbm_pkg::ProdW;
   localparam int unsigned QuotW = upbm_pkg::QuotW;
   localparam int unsigned CycW  = $clog2(ProdW);
   localparam int unsigned StepW = $clog2(QuotW);
   localparam logic [CycW-1:0]  SerLast = CycW'(ProdW - 1);
   localparam logic [StepW-1:0] DivLast = StepW'(QuotW - 1);

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SER  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_RND  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CycW-1:0]  cnt_ff, cnt_in;
   logic [StepW-1:0] step_ff, step_in;

   // counter snapshot, shifted out LSB first
   logic [upbm_pkg::NumCtr-1:0][CntW-1:0] ctr_ff, ctr_in;

   // serial arithmetic state
   logic [3:0] tcarry_ff, tcarry_in;    // ten-operand adder carry, at most 9
   logic icarry_ff, icarry_in;
   logic tborrow_ff, tborrow_in;
   logic iborrow_ff, iborrow_in;
   logic bborrow_ff, bborrow_in;
   logic gt_ff, gt_in;                  // dI > dT so far
   logic nz_ff, nz_in;                  // dT has a set bit so far
   logic [5:0] hist_ff, hist_in;        // last six bits of dT - dI
   logic [1:0] mcarry_ff, mcarry_in;    // carry of the x100 adder

   logic [CntW-1:0] lt_ff, lt_in;       // previous total, rotated in place
   logic [CntW-1:0] li_ff, li_in;       // previous idle sum
   logic [CntW-1:0] d_ff, d_in;         // dT, collected LSB first
   logic [ProdW-1:0] prod_ff, prod_in;  // 100*(dT-dI), then division remainder
   logic [ProdW-2:0] dsh_ff, dsh_in;    // shifted divisor
   logic [QuotW-1:0] q_ff, q_in;

   logic primed_ff, primed_in;
   logic [upbm_pkg::BarW-1:0] bar_ff, bar_in;
   logic rsp_valid_ff, rsp_valid_in;
   upbm_pkg::rsp_payload_type rsp_ff, rsp_in;

   // bit-slice signals
   logic live;
   logic [upbm_pkg::NumCtr-1:0] lsb_vec;
   logic [4:0] sum5;
   logic tb, ib, dtb, dib, bb, bcur, mbit;
   logic [2:0] msum;

   // division and rounding
   logic [ProdW-1:0] dsh_ext;
   logic ge, rnd, commit;
   logic [upbm_pkg::PctW-1:0] pct;
   logic [upbm_pkg::StatW-1:0] status;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      for (int i = 0; i < upbm_pkg::NumCtr; i++) begin
         lsb_vec[i] = ctr_ff[i][0];
      end
   end

   // One bit of every sum and difference per cycle. Bits past 64 feed zeros
   // into the x100 adder so that its top carries drain out.
   assign live = ~cnt_ff[CycW-1];
   assign sum5 = 5'(tcarry_ff) + 5'($countones(lsb_vec));
   assign tb   = sum5[0];
   assign ib   = ctr_ff[3][0] ^ ctr_ff[4][0] ^ icarry_ff;
   assign dtb  = tb ^ lt_ff[0] ^ tborrow_ff;
   assign dib  = ib ^ li_ff[0] ^ iborrow_ff;
   assign bb   = dtb ^ dib ^ bborrow_ff;
   assign bcur = live & bb;
   // 100 = 2^6 + 2^5 + 2^2
   assign msum = 3'(hist_ff[1]) + 3'(hist_ff[4]) + 3'(hist_ff[5]) + 3'(mcarry_ff);
   assign mbit = msum[0];

   assign dsh_ext = {1'b0, dsh_ff};
   assign ge      = (prod_ff >= dsh_ext);
   // round half up: remainder r against d - r, i.e. 2r >= d
   assign rnd     = ({prod_ff[CntW-1:0], 1'b0} >= {1'b0, d_ff});
   assign pct     = q_ff + upbm_pkg::PctW'(rnd);

   always_comb begin
      priority if (!primed_ff) begin
         status = upbm_pkg::ST_FIRST;
      end else if (!nz_ff) begin
         status = upbm_pkg::ST_ZERO;
      end else if (gt_ff) begin
         status = upbm_pkg::ST_IDLE;
      end else begin
         status = upbm_pkg::ST_OK;
      end
   end

   // commit only when the output register is free or being emptied
   assign commit = (state_ff == S_RND) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      ctr_in     = ctr_ff;
      tcarry_in  = tcarry_ff;
      icarry_in  = icarry_ff;
      tborrow_in = tborrow_ff;
      iborrow_in = iborrow_ff;
      bborrow_in = bborrow_ff;
      gt_in      = gt_ff;
      nz_in      = nz_ff;
      hist_in    = hist_ff;
      mcarry_in  = mcarry_ff;
      lt_in      = lt_ff;
      li_in      = li_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      dsh_in     = dsh_ff;
      q_in       = q_ff;
      primed_in  = primed_ff;
      bar_in     = bar_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               // load the snapshot, clear all serial carries
               ctr_in[0]  = req_chan.payload.user_ticks;
               ctr_in[1]  = req_chan.payload.nice_ticks;
               ctr_in[2]  = req_chan.payload.system_ticks;
               ctr_in[3]  = req_chan.payload.idle_ticks;
               ctr_in[4]  = req_chan.payload.iowait_ticks;
               ctr_in[5]  = req_chan.payload.irq_ticks;
               ctr_in[6]  = req_chan.payload.softirq_ticks;
               ctr_in[7]  = req_chan.payload.steal_ticks;
               ctr_in[8]  = req_chan.payload.guest_ticks;
               ctr_in[9]  = req_chan.payload.guest_nice_ticks;
               tcarry_in  = '0;
               icarry_in  = 1'b0;
               tborrow_in = 1'b0;
               iborrow_in = 1'b0;
               bborrow_in = 1'b0;
               gt_in      = 1'b0;
               nz_in      = 1'b0;
               hist_in    = '0;
               mcarry_in  = '0;
               cnt_in     = '0;
               state_in   = S_SER;
            end
         end
         S_SER: begin
            for (int i = 0; i < upbm_pkg::NumCtr; i++) begin
               ctr_in[i] = {1'b0, ctr_ff[i][CntW-1:1]};
            end
            if (live) begin
               tcarry_in  = sum5[4:1];
               icarry_in  = (ctr_ff[3][0] & ctr_ff[4][0]) |
                            (icarry_ff & (ctr_ff[3][0] ^ ctr_ff[4][0]));
               tborrow_in = (~tb & lt_ff[0]) | (~(tb ^ lt_ff[0]) & tborrow_ff);
               iborrow_in = (~ib & li_ff[0]) | (~(ib ^ li_ff[0]) & iborrow_ff);
               bborrow_in = (~dtb & dib) | (~(dtb ^ dib) & bborrow_ff);
               gt_in      = (dib & ~dtb) | (~(dib ^ dtb) & gt_ff);
               nz_in      = nz_ff | dtb;
               // rotate the new snapshot into the previous-value registers
               lt_in      = {tb, lt_ff[CntW-1:1]};
               li_in      = {ib, li_ff[CntW-1:1]};
               d_in       = {dtb, d_ff[CntW-1:1]};
            end
            hist_in   = {hist_ff[4:0], bcur};
            mcarry_in = msum[2:1];
            prod_in   = {mbit, prod_ff[ProdW-1:1]};
            cnt_in    = cnt_ff + CycW'(1);
            if (cnt_ff == SerLast) begin
               dsh_in   = {d_ff, (QuotW - 1)'(0)};
               q_in     = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per step
            if (ge) begin
               prod_in = prod_ff - dsh_ext;
            end
            q_in    = {q_ff[QuotW-2:0], ge};
            dsh_in  = {1'b0, dsh_ff[ProdW-2:1]};
            step_in = step_ff + StepW'(1);
            if (step_ff == DivLast) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            if (commit) begin
               rsp_in.status = status;
               if (status == upbm_pkg::ST_OK) begin
                  rsp_in.busy_percent = pct;
                  bar_in              = upbm_pkg::bar_of(pct);
                  rsp_in.led_bar      = upbm_pkg::bar_of(pct);
               end else begin
                  // hold the bar
                  rsp_in.busy_percent = '0;
                  rsp_in.led_bar      = bar_ff;
               end
               primed_in    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         bar_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         bar_ff       <= bar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      step_ff    <= step_in;
      ctr_ff     <= ctr_in;
      tcarry_ff  <= tcarry_in;
      icarry_ff  <= icarry_in;
      tborrow_ff <= tborrow_in;
      iborrow_ff <= iborrow_in;
      bborrow_ff <= bborrow_in;
      gt_ff      <= gt_in;
      nz_ff      <= nz_in;
      hist_ff    <= hist_in;
      mcarry_ff  <= mcarry_in;
      lt_ff      <= lt_in;
      li_ff      <= li_in;
      d_ff       <= d_in;
      prod_ff    <= prod_in;
      dsh_ff     <= dsh_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ----- sv/upbm_checker.sv -----
`include "utilization_percent_bar_meter_core_defines.svh"

module upbm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [upbm_pkg::StatW-1:0]         rsp_status,
   input logic [upbm_pkg::PctW-1:0]          rsp_busy_percent,
   input logic [upbm_pkg::BarW-1:0]          rsp_led_bar
);

   localparam logic [upbm_pkg::BarW-1:0] BarOne = upbm_pkg::BarW'(1);

   // a result stays offered until taken
   `UPBM_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // one item in flight: ready drops right after an accept
   `UPBM_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_valid && req_ready, !req_ready, "second item taken")

   `UPBM_ASSERT_NOW(a_pct_zero, clock, reset,
      rsp_valid && rsp_status != upbm_pkg::ST_OK, rsp_busy_percent == '0,
      "percent set on non-ok status")

   `UPBM_ASSERT_NOW(a_bar_thermo, clock, reset,
      rsp_valid, ((rsp_led_bar + BarOne) & rsp_led_bar) == '0,
      "bar not a thermometer")

   `UPBM_ASSERT_NOW(a_bar_match, clock, reset,
      rsp_valid && rsp_status == upbm_pkg::ST_OK,
      rsp_led_bar == upbm_pkg::bar_of(rsp_busy_percent),
      "bar does not match percent")

endmodule

bind utilization_percent_bar_meter_core upbm_checker u_upbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.payload.status),
   .rsp_busy_percent (rsp_chan.payload.busy_percent),
   .rsp_led_bar      (rsp_chan.payload.led_bar)
);
